// ===== rtl/mwlk_pkg.sv =====
// Shared types, constants and letter tables for the Morse word LED keyer.
`timescale 1ns / 1ps

package mwlk_pkg;

  localparam int WORD_LETTERS = 4;
  localparam int LIDX_W       = (WORD_LETTERS > 1) ? $clog2(WORD_LETTERS) : 1;
  localparam int NUM_REGS     = 4;
  localparam int CODE_W       = 3;
  localparam int CFG_IDX_W    = 3;
  localparam int LEN_W        = 3;
  localparam int SYM_W        = 2;

  typedef logic [CODE_W-1:0]                code_t;
  typedef logic [NUM_REGS-1:0][CODE_W-1:0]  letter_regs_t;
  typedef logic [LIDX_W-1:0]                lidx_t;
  typedef logic [SYM_W-1:0]                 sym_t;
  typedef logic [LEN_W-1:0]                 len_t;

  typedef enum logic [2:0] {
    KIND_DOT     = 3'd0,
    KIND_DASH    = 3'd1,
    KIND_SYMGAP  = 3'd2,
    KIND_LETGAP  = 3'd3,
    KIND_WORDGAP = 3'd4
  } kind_t;

  localparam code_t LETTER_A = 3'd0;
  localparam code_t LETTER_E = 3'd1;
  localparam code_t LETTER_I = 3'd2;
  localparam code_t LETTER_P = 3'd3;
  localparam code_t LETTER_R = 3'd4;

  localparam letter_regs_t LETTER_RST = {LETTER_R, LETTER_A, LETTER_E, LETTER_P};

  // per-item status handed from the sequencer to the output stage
  typedef struct packed {
    logic led_on;
    logic word_gap;
  } key_stat_t;

  function automatic code_t code_sat(input code_t c);
    code_sat = (c > LETTER_R) ? LETTER_R : c;
  endfunction

  function automatic len_t letter_len(input code_t c);
    case (code_sat(c))
      LETTER_A: letter_len = 3'd2;
      LETTER_E: letter_len = 3'd1;
      LETTER_I: letter_len = 3'd2;
      LETTER_P: letter_len = 3'd4;
      default:  letter_len = 3'd3;
    endcase
  endfunction

  // bit i set for a dash at symbol i
  function automatic logic [3:0] letter_pat(input code_t c);
    case (code_sat(c))
      LETTER_A: letter_pat = 4'b0010;
      LETTER_E: letter_pat = 4'b0000;
      LETTER_I: letter_pat = 4'b0000;
      LETTER_P: letter_pat = 4'b0110;
      default:  letter_pat = 4'b0010;
    endcase
  endfunction

  // symbols past the end of the letter read as a dot
  function automatic logic letter_dash(input code_t c, input sym_t s);
    logic [3:0] pat;
    pat = letter_pat(c);
    letter_dash = ({1'b0, s} < letter_len(c)) ? pat[s] : 1'b0;
  endfunction

  function automatic len_t kind_len(input kind_t k);
    case (k)
      KIND_DASH:    kind_len = 3'd3;
      KIND_LETGAP:  kind_len = 3'd3;
      KIND_WORDGAP: kind_len = 3'd7;
      default:      kind_len = 3'd1;
    endcase
  endfunction

endpackage

// ===== rtl/mwlk_cfg_regs.sv =====
// Letter code registers written through the configuration port.
`timescale 1ns / 1ps

module mwlk_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  input  logic [mwlk_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mwlk_pkg::CODE_W-1:0]          cfg_data,
  output logic                                 cfg_ready,
  output mwlk_pkg::letter_regs_t               letters
);

  mwlk_pkg::letter_regs_t letters_r;

  assign cfg_ready = 1'b1;
  assign letters   = letters_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      letters_r <= mwlk_pkg::LETTER_RST;
    end else if (cfg_valid && cfg_ready &&
                 (cfg_index < mwlk_pkg::CFG_IDX_W'(mwlk_pkg::NUM_REGS))) begin
      letters_r[cfg_index[1:0]] <= cfg_data;
    end
  end

endmodule

// ===== rtl/mwlk_seq.sv =====
// Element sequencer: keyer state and its per-tick update.
`timescale 1ns / 1ps

module mwlk_seq (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step,
  input  logic                     tick,
  input  mwlk_pkg::letter_regs_t   letters,
  output mwlk_pkg::key_stat_t      stat
);

  localparam logic [mwlk_pkg::LIDX_W:0] WL =
    (mwlk_pkg::LIDX_W + 1)'(mwlk_pkg::WORD_LETTERS);
  localparam mwlk_pkg::lidx_t LAST_LI =
    mwlk_pkg::LIDX_W'(mwlk_pkg::WORD_LETTERS - 1);

  mwlk_pkg::kind_t kind_r, kind_nxt;
  mwlk_pkg::lidx_t li_r, li_nxt;
  mwlk_pkg::sym_t  sym_r, sym_nxt;
  mwlk_pkg::len_t  len_r, len_nxt;
  mwlk_pkg::len_t  cnt_r, cnt_nxt;

  mwlk_pkg::len_t          cnt_inc;
  logic [mwlk_pkg::LIDX_W+1:0] li_ext, li_nxt_ext;
  mwlk_pkg::code_t         cur_code, nxt_code;
  logic                    sym_last, li_last, take_sym;

  assign stat.led_on   = (kind_r == mwlk_pkg::KIND_DOT) || (kind_r == mwlk_pkg::KIND_DASH);
  assign stat.word_gap = (kind_r == mwlk_pkg::KIND_WORDGAP);

  always_comb begin
    cnt_inc    = cnt_r + 3'd1;
    li_ext     = {2'b00, li_r};
    cur_code   = letters[li_ext[1:0]];
    sym_last   = ({1'b0, sym_r} + 3'd1) >= mwlk_pkg::letter_len(cur_code);
    li_last    = ({1'b0, li_r} + 1'b1) >= WL;
    kind_nxt   = kind_r;
    li_nxt     = li_r;
    sym_nxt    = sym_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    take_sym   = 1'b0;
    if (tick) begin
      if (cnt_inc >= len_r) begin
        cnt_nxt = '0;
        unique case (kind_r) inside
          mwlk_pkg::KIND_DOT, mwlk_pkg::KIND_DASH: begin
            if (sym_last) begin
              kind_nxt = li_last ? mwlk_pkg::KIND_WORDGAP : mwlk_pkg::KIND_LETGAP;
            end else begin
              kind_nxt = mwlk_pkg::KIND_SYMGAP;
            end
          end
          mwlk_pkg::KIND_SYMGAP: begin
            sym_nxt  = sym_r + 2'd1;
            take_sym = 1'b1;
          end
          mwlk_pkg::KIND_LETGAP: begin
            li_nxt   = li_last ? '0 : li_r + 1'b1;
            sym_nxt  = '0;
            take_sym = 1'b1;
          end
          default: begin
            li_nxt   = '0;
            sym_nxt  = '0;
            take_sym = 1'b1;
          end
        endcase
      end else begin
        cnt_nxt = cnt_inc;
      end
    end
    li_nxt_ext = {2'b00, li_nxt};
    nxt_code   = letters[li_nxt_ext[1:0]];
    if (take_sym) begin
      kind_nxt = mwlk_pkg::letter_dash(nxt_code, sym_nxt) ?
                 mwlk_pkg::KIND_DASH : mwlk_pkg::KIND_DOT;
    end
    if (tick && (cnt_inc >= len_r)) begin
      len_nxt = mwlk_pkg::kind_len(kind_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= mwlk_pkg::letter_dash(mwlk_pkg::LETTER_RST[0], '0) ?
                mwlk_pkg::KIND_DASH : mwlk_pkg::KIND_DOT;
      len_r  <= mwlk_pkg::letter_dash(mwlk_pkg::LETTER_RST[0], '0) ? 3'd3 : 3'd1;
      li_r   <= '0;
      sym_r  <= '0;
      cnt_r  <= '0;
    end else if (step) begin
      kind_r <= kind_nxt;
      len_r  <= len_nxt;
      li_r   <= li_nxt;
      sym_r  <= sym_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < len_r)
    else $error("unit count reached element length");

  a_len_matches_kind: assert property (@(posedge clk) disable iff (!rst_n)
    len_r == mwlk_pkg::kind_len(kind_r))
    else $error("element length disagrees with kind");

  a_wordgap_last_letter: assert property (@(posedge clk) disable iff (!rst_n)
    (kind_r == mwlk_pkg::KIND_WORDGAP) |-> (li_r == LAST_LI))
    else $error("word gap outside last letter");
`endif

endmodule

// ===== rtl/morse_word_led_keyer_top.sv =====
// Top level of the Morse word LED keyer: input stage, sequencer, result stage.
`timescale 1ns / 1ps

// channel | signals                                    | direction
// in      | in_valid, in_stall, in_tick                | item in
// out     | out_valid, out_stall, out_led_on, out_word_gap | item out
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data  | register write
//
// One item per cycle sustained while out_stall is low; each item passes the input register, then the result register.
// The result reflects the element in force before the item's tick advances it.
// Synchronous active-low reset restores the default word (p e a r), first dot.
// out_stall holds the result register and backs up into in_stall the same cycle.

module morse_word_led_keyer_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_tick,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_led_on,
  output logic                                 out_word_gap,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mwlk_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mwlk_pkg::CODE_W-1:0]          cfg_data
);

  mwlk_pkg::letter_regs_t letters;
  mwlk_pkg::key_stat_t    stat;

  logic s1_valid_r;
  logic s1_tick_r;
  logic out_valid_r;
  mwlk_pkg::key_stat_t out_stat_r;
  logic out_load;

  assign out_load  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !out_load;
  assign out_valid = out_valid_r;
  assign out_led_on   = out_stat_r.led_on;
  assign out_word_gap = out_stat_r.word_gap;

  mwlk_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .letters   (letters)
  );

  mwlk_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (out_load),
    .tick    (s1_tick_r),
    .letters (letters),
    .stat    (stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_tick_r <= in_tick;
    end
    if (out_load) begin
      out_stat_r <= stat;
    end
  end

`ifndef SYNTHESIS
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a held item");
`endif

endmodule

// ===== tb/sv/morse_word_led_keyer_checker.sv =====
// Checker for the Morse word LED keyer: predicts each result from the accepted items and compares.
`timescale 1ns / 1ps

module morse_word_led_keyer_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic                           in_tick,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic                           out_led_on,
  input  logic                           out_word_gap,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [mwlk_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mwlk_pkg::CODE_W-1:0]    cfg_data,
  output int                             fail_count,
  output int                             pending
);

  import mwlk_pkg::*;

  kind_t     cur_kind;
  lidx_t     letter_pos;
  sym_t      sym_pos;
  len_t      elem_units;
  len_t      units_done;
  code_t     word_code [NUM_REGS];
  key_stat_t keys_due [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic code_t letter_code(input lidx_t pos);
    code_t c;
    c = word_code[pos % NUM_REGS];
    return (c > LETTER_R) ? LETTER_R : c;
  endfunction

  function automatic int symbols_in(input code_t c);
    case (c)
      LETTER_A: return 2;
      LETTER_E: return 1;
      LETTER_I: return 2;
      LETTER_P: return 4;
      default:  return 3;
    endcase
  endfunction

  // bit i marks a dash at symbol i
  function automatic logic [3:0] dash_bits(input code_t c);
    case (c)
      LETTER_A: return 4'b0010;
      LETTER_E: return 4'b0000;
      LETTER_I: return 4'b0000;
      LETTER_P: return 4'b0110;
      default:  return 4'b0010;
    endcase
  endfunction

  function automatic void begin_element(input kind_t k);
    cur_kind = k;
    case (k)
      KIND_DASH, KIND_LETGAP: elem_units = 3'd3;
      KIND_WORDGAP:           elem_units = 3'd7;
      default:                elem_units = 3'd1;
    endcase
    units_done = '0;
  endfunction

  // a symbol beyond the letter's end keys as a dot
  function automatic void begin_symbol();
    code_t      c;
    logic [3:0] bits;
    c = letter_code(letter_pos);
    bits = dash_bits(c);
    if (int'(sym_pos) < symbols_in(c) && bits[sym_pos]) begin
      begin_element(KIND_DASH);
    end else begin
      begin_element(KIND_DOT);
    end
  endfunction

  function automatic void next_element();
    code_t c;
    case (cur_kind)
      KIND_DOT, KIND_DASH: begin
        c = letter_code(letter_pos);
        if (int'(sym_pos) + 1 >= symbols_in(c)) begin
          if (int'(letter_pos) + 1 >= WORD_LETTERS) begin
            begin_element(KIND_WORDGAP);
          end else begin
            begin_element(KIND_LETGAP);
          end
        end else begin
          begin_element(KIND_SYMGAP);
        end
      end
      KIND_SYMGAP: begin
        sym_pos = sym_pos + 1'b1;
        begin_symbol();
      end
      KIND_LETGAP: begin
        if (int'(letter_pos) + 1 >= WORD_LETTERS) begin
          letter_pos = '0;
        end else begin
          letter_pos = letter_pos + 1'b1;
        end
        sym_pos = '0;
        begin_symbol();
      end
      default: begin
        letter_pos = '0;
        sym_pos    = '0;
        begin_symbol();
      end
    endcase
  endfunction

  // status of the element in force, then advance on a tick
  function automatic key_stat_t key_one(input logic tick);
    key_stat_t k;
    k.led_on   = (cur_kind == KIND_DOT) || (cur_kind == KIND_DASH);
    k.word_gap = (cur_kind == KIND_WORDGAP);
    if (tick) begin
      units_done = units_done + 1'b1;
      if (units_done >= elem_units) next_element();
    end
    return k;
  endfunction

  function automatic void reset_keyer();
    word_code[0] = LETTER_P;
    word_code[1] = LETTER_E;
    word_code[2] = LETTER_A;
    word_code[3] = LETTER_R;
    letter_pos   = '0;
    sym_pos      = '0;
    begin_symbol();
  endfunction

  always @(posedge clk) begin
    key_stat_t want;
    if (!rst_n) begin
      reset_keyer();
      keys_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (keys_due.size() == 0) begin
          $display("%0t: unexpected item: expected none, actual led_on %0b word_gap %0b",
                   $time, out_led_on, out_word_gap);
          fail_count = fail_count + 1;
        end else begin
          want = keys_due.pop_front();
          if (out_led_on !== want.led_on) begin
            $display("%0t: led_on expected %0b actual %0b", $time, want.led_on, out_led_on);
            fail_count = fail_count + 1;
          end
          if (out_word_gap !== want.word_gap) begin
            $display("%0t: word_gap expected %0b actual %0b", $time, want.word_gap,
                     out_word_gap);
            fail_count = fail_count + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready && cfg_index < NUM_REGS) word_code[cfg_index] = cfg_data;
      if (in_valid && !in_stall) keys_due.push_back(key_one(in_tick));
    end
    pending <= keys_due.size();
  end

endmodule

// ===== tb/sv/morse_word_led_keyer_top_tb.sv =====
// Testbench top for the Morse word LED keyer: stimulus, idling, register writes and verdict.
`timescale 1ns / 1ps

module morse_word_led_keyer_top_tb;

  import mwlk_pkg::*;

  localparam int REG_LETTER_0  = 0;
  localparam int REG_LETTER_1  = 1;
  localparam int REG_LETTER_2  = 2;
  localparam int REG_LETTER_3  = 3;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASES        = 11;
  localparam int PHASE_ITEMS   = 100;
  localparam int SETTLE_CYCLES = 8;

  logic                 clk;
  logic                 rst_n        = 1'b0;
  logic                 in_valid     = 1'b0;
  logic                 in_stall;
  logic                 in_tick      = 1'b0;
  logic                 out_valid;
  logic                 out_stall    = 1'b0;
  logic                 out_led_on;
  logic                 out_word_gap;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [CODE_W-1:0]    cfg_data     = '0;
  logic                 idling       = 1'b1;
  int                   fails;
  int                   pending;
  int                   cycles       = 0;
  int                   hold_cnt     = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  morse_word_led_keyer_top uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_tick      (in_tick),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_led_on   (out_led_on),
    .out_word_gap (out_word_gap),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  morse_word_led_keyer_checker keyer_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_tick      (in_tick),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_led_on   (out_led_on),
    .out_word_gap (out_word_gap),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fails),
    .pending      (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("morse_word_led_keyer_top_tb NOT OK");
      $finish;
    end
  end

  // result-side stall bursts, only while idling is set
  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (idling && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      hold_cnt  <= $urandom_range(0, 11);
    end else begin
      out_stall <= 1'b0;
      hold_cnt  <= $urandom_range(0, 15);
    end
  end

  task automatic send_tick(input logic tick);
    int gap;
    if (idling && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_tick  <= tick;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // leaves cfg_valid high so back-to-back writes need no low step
  task automatic write_reg(input int idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data  <= CODE_W'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_word(input code_t c0, input code_t c1, input code_t c2, input code_t c3);
    write_reg(NUM_REGS + $urandom_range(0, 3), $urandom_range(0, 7));
    write_reg(REG_LETTER_0, int'(c0));
    write_reg(REG_LETTER_1, int'(c1));
    write_reg(REG_LETTER_2, int'(c2));
    write_reg(REG_LETTER_3, int'(c3));
    write_reg(NUM_REGS + $urandom_range(0, 3), $urandom_range(0, 7));
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [16:0] opening;
    code_t       w0, w1, w2, w3;
    opening = 17'b1_1011_1111_1110_1100;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // default word with idle ticks mixed in
    for (int i = 0; i < 17; i++) send_tick(opening[i]);
    drain_results();
    // out-of-table codes, rewritten mid-word, in a letter gap
    load_word(3'd7, 3'd5, 3'd6, LETTER_A);
    for (int i = 0; i < 8; i++) send_tick(i != 2);
    drain_results();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin w0 = LETTER_A; w1 = LETTER_A; w2 = LETTER_A; w3 = LETTER_A; end
        1: begin w0 = LETTER_R; w1 = LETTER_R; w2 = LETTER_R; w3 = LETTER_R; end
        2: begin w0 = 3'd7;     w1 = 3'd7;     w2 = 3'd7;     w3 = 3'd7;     end
        3: begin w0 = LETTER_E; w1 = LETTER_E; w2 = LETTER_E; w3 = LETTER_E; end
        4: begin w0 = LETTER_P; w1 = LETTER_P; w2 = LETTER_P; w3 = LETTER_P; end
        5: begin w0 = LETTER_I; w1 = 3'd7;     w2 = LETTER_R; w3 = LETTER_E; end
        default: begin
          w0 = code_t'($urandom_range(0, 7));
          w1 = code_t'($urandom_range(0, 7));
          w2 = code_t'($urandom_range(0, 7));
          w3 = code_t'($urandom_range(0, 7));
        end
      endcase
      if (ph == PHASES - 1) idling <= 1'b0;
      load_word(w0, w1, w2, w3);
      repeat (PHASE_ITEMS) send_tick($urandom_range(0, 7) != 0);
      drain_results();
    end

    if (fails == 0) begin
      $display("morse_word_led_keyer_top_tb OK");
    end else begin
      $display("morse_word_led_keyer_top_tb NOT OK");
    end
    $finish;
  end

endmodule
